// ===== rtl/bhrsp_pkg.sv =====
// Package: widths, codes and item types of the binary HTTP response parser.
`default_nettype none
package bhrsp_pkg;

   localparam int LENGTH_BITS  = 62;
   localparam int VARINT_BITS  = 62;
   localparam int BYTE_W       = 8;
   localparam int CLASS_W      = 4;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 10;
   localparam int ERR_W        = 3;
   localparam int LEFT_W       = 3;
   localparam int NBYTES_W     = 4;

   localparam int STATUS_INFO_MIN  = 100;
   localparam int STATUS_INFO_MAX  = 199;
   localparam int STATUS_FINAL_MIN = 200;
   localparam int STATUS_FINAL_MAX = 599;
   localparam int FRAMING_KNOWN    = 1;

   typedef enum logic [CLASS_W-1:0] {
      PH_FRAMING = 4'd0,
      PH_STATUS  = 4'd1,
      PH_SECLEN  = 4'd2,
      PH_NAMELEN = 4'd3,
      PH_NAME    = 4'd4,
      PH_VALLEN  = 4'd5,
      PH_VALUE   = 4'd6,
      PH_CONTLEN = 4'd7,
      PH_CONTENT = 4'd8,
      PH_PAD     = 4'd9
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      SEC_INFO    = 2'd0,
      SEC_FINAL   = 2'd1,
      SEC_TRAILER = 2'd2
   } section_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_FRAMING   = 3'd1,
      ERR_STATUS    = 3'd2,
      ERR_EMPTY     = 3'd3,
      ERR_OVERRUN   = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   byte_out;
      logic [CLASS_W-1:0]  byte_class;
      logic [KIND_W-1:0]   section_kind;
      logic                field_end;
      logic [STATUS_W-1:0] final_status;
      logic [ERR_W-1:0]    error_code;
      logic                message_done;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== rtl/bhrsp_req_if.sv =====
// Input channel: one message byte per item with its end-of-message mark.
`default_nettype none
interface bhrsp_req_if;
   logic                          valid;
   logic                          ready;
   logic [bhrsp_pkg::BYTE_W-1:0]  data_byte;
   logic                          last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/bhrsp_rsp_if.sv =====
// Result channel: one tagged byte per item.
`default_nettype none
interface bhrsp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bhrsp_pkg::BYTE_W-1:0]    byte_out;
   logic [bhrsp_pkg::CLASS_W-1:0]   byte_class;
   logic [bhrsp_pkg::KIND_W-1:0]    section_kind;
   logic                            field_end;
   logic [bhrsp_pkg::STATUS_W-1:0]  final_status;
   logic [bhrsp_pkg::ERR_W-1:0]     error_code;
   logic                            message_done;

   modport source (output valid, output byte_out, output byte_class, output section_kind,
                    output field_end, output final_status, output error_code,
                    output message_done, input ready);
   modport sink   (input valid, input byte_out, input byte_class, input section_kind,
                   input field_end, input final_status, input error_code,
                   input message_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/bhrsp_core.sv =====
// Parser state registers and the per-byte next-state and tagging logic.
`default_nettype none
module bhrsp_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [bhrsp_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic                          last_byte,
   output bhrsp_pkg::rsp_item_type            result
);

   localparam int LB = bhrsp_pkg::LENGTH_BITS;
   localparam int VB = bhrsp_pkg::VARINT_BITS;

   bhrsp_pkg::phase_type             ph_ff, ph_in, ph_step;
   logic [VB-1:0]                    acc_ff, acc_in, acc_step;
   logic [bhrsp_pkg::LEFT_W-1:0]     left_ff, left_in, left_step;
   logic [LB-1:0]                    sec_ff, sec_in, sec_step;
   logic [LB-1:0]                    item_ff, item_in, item_step;
   bhrsp_pkg::section_type           cur_ff, cur_in, cur_step;
   logic [bhrsp_pkg::STATUS_W-1:0]   status_ff, status_in, status_step;
   bhrsp_pkg::err_type               err_ff, err_in, err_step;

   bhrsp_pkg::phase_type             cls;
   logic [bhrsp_pkg::KIND_W-1:0]     kind;
   logic                             fend;
   logic                             done;
   logic                             in_sec;
   logic [bhrsp_pkg::NBYTES_W-1:0]   nbytes;
   logic [VB-1:0]                    acc_new;
   logic [bhrsp_pkg::LEFT_W-1:0]     left_new;

   function automatic bhrsp_pkg::phase_type after_section(bhrsp_pkg::section_type s);
      bhrsp_pkg::phase_type p;
      unique case (s)
         bhrsp_pkg::SEC_INFO:  p = bhrsp_pkg::PH_STATUS;
         bhrsp_pkg::SEC_FINAL: p = bhrsp_pkg::PH_CONTLEN;
         default:              p = bhrsp_pkg::PH_PAD;
      endcase
      return p;
   endfunction

   always_comb begin
      ph_step     = ph_ff;
      acc_step    = acc_ff;
      left_step   = left_ff;
      sec_step    = sec_ff;
      item_step   = item_ff;
      cur_step    = cur_ff;
      status_step = status_ff;
      err_step    = err_ff;
      cls         = bhrsp_pkg::PH_PAD;
      kind        = '0;
      fend        = 1'b0;
      done        = 1'b0;
      in_sec      = (ph_ff == bhrsp_pkg::PH_NAMELEN) || (ph_ff == bhrsp_pkg::PH_VALLEN);
      nbytes      = bhrsp_pkg::NBYTES_W'(1) << data_byte[7:6];
      acc_new     = '0;
      left_new    = '0;

      if (err_ff == bhrsp_pkg::ERR_NONE) begin
         cls = ph_ff;
         if (ph_ff == bhrsp_pkg::PH_SECLEN || ph_ff == bhrsp_pkg::PH_NAMELEN ||
             ph_ff == bhrsp_pkg::PH_NAME || ph_ff == bhrsp_pkg::PH_VALLEN ||
             ph_ff == bhrsp_pkg::PH_VALUE) begin
            kind = cur_ff;
         end
         unique case (ph_ff) inside
            bhrsp_pkg::PH_FRAMING, bhrsp_pkg::PH_STATUS, bhrsp_pkg::PH_SECLEN,
            bhrsp_pkg::PH_NAMELEN, bhrsp_pkg::PH_VALLEN, bhrsp_pkg::PH_CONTLEN: begin
               if (left_ff == '0 && in_sec && LB'(nbytes) > sec_ff) begin
                  err_step = bhrsp_pkg::ERR_OVERRUN;
               end else begin
                  if (left_ff == '0) begin
                     acc_new  = {{(VB-6){1'b0}}, data_byte[5:0]};
                     left_new = bhrsp_pkg::LEFT_W'(nbytes - bhrsp_pkg::NBYTES_W'(1));
                  end else begin
                     acc_new  = {acc_ff[VB-9:0], data_byte};
                     left_new = left_ff - bhrsp_pkg::LEFT_W'(1);
                  end
                  if (in_sec) begin
                     sec_step = sec_ff - LB'(1);
                  end
                  acc_step  = acc_new;
                  left_step = left_new;
                  if (left_new == '0) begin
                     acc_step = '0;
                     // acc_new >= sec_ff here equals value > decremented section count
                     unique case (ph_ff)
                        bhrsp_pkg::PH_FRAMING: begin
                           if (acc_new != VB'(bhrsp_pkg::FRAMING_KNOWN)) begin
                              err_step = bhrsp_pkg::ERR_FRAMING;
                           end else begin
                              ph_step = bhrsp_pkg::PH_STATUS;
                           end
                        end
                        bhrsp_pkg::PH_STATUS: begin
                           if (acc_new >= VB'(bhrsp_pkg::STATUS_FINAL_MIN) &&
                               acc_new <= VB'(bhrsp_pkg::STATUS_FINAL_MAX)) begin
                              status_step = acc_new[bhrsp_pkg::STATUS_W-1:0];
                              cur_step    = bhrsp_pkg::SEC_FINAL;
                              ph_step     = bhrsp_pkg::PH_SECLEN;
                           end else if (acc_new >= VB'(bhrsp_pkg::STATUS_INFO_MIN) &&
                                        acc_new <= VB'(bhrsp_pkg::STATUS_INFO_MAX)) begin
                              cur_step = bhrsp_pkg::SEC_INFO;
                              ph_step  = bhrsp_pkg::PH_SECLEN;
                           end else begin
                              err_step = bhrsp_pkg::ERR_STATUS;
                           end
                        end
                        bhrsp_pkg::PH_SECLEN: begin
                           if ((acc_new >> LB) != '0) begin
                              err_step = bhrsp_pkg::ERR_TRUNCATED;
                           end else begin
                              sec_step = acc_new[LB-1:0];
                              if (acc_new == '0) begin
                                 ph_step = after_section(cur_ff);
                              end else begin
                                 ph_step = bhrsp_pkg::PH_NAMELEN;
                              end
                           end
                        end
                        bhrsp_pkg::PH_NAMELEN: begin
                           if (acc_new == '0) begin
                              err_step = bhrsp_pkg::ERR_EMPTY;
                           end else if (acc_new >= VB'(sec_ff)) begin
                              err_step = bhrsp_pkg::ERR_OVERRUN;
                           end else begin
                              item_step = acc_new[LB-1:0];
                              ph_step   = bhrsp_pkg::PH_NAME;
                           end
                        end
                        bhrsp_pkg::PH_VALLEN: begin
                           if (acc_new >= VB'(sec_ff)) begin
                              err_step = bhrsp_pkg::ERR_OVERRUN;
                           end else if (acc_new == '0) begin
                              fend = 1'b1;
                              if (sec_ff == LB'(1)) begin
                                 ph_step = after_section(cur_ff);
                              end else begin
                                 ph_step = bhrsp_pkg::PH_NAMELEN;
                              end
                           end else begin
                              item_step = acc_new[LB-1:0];
                              ph_step   = bhrsp_pkg::PH_VALUE;
                           end
                        end
                        default: begin
                           if ((acc_new >> LB) != '0) begin
                              err_step = bhrsp_pkg::ERR_TRUNCATED;
                           end else if (acc_new == '0) begin
                              cur_step = bhrsp_pkg::SEC_TRAILER;
                              ph_step  = bhrsp_pkg::PH_SECLEN;
                           end else begin
                              item_step = acc_new[LB-1:0];
                              ph_step   = bhrsp_pkg::PH_CONTENT;
                           end
                        end
                     endcase
                  end
               end
            end
            bhrsp_pkg::PH_NAME, bhrsp_pkg::PH_VALUE: begin
               item_step = item_ff - LB'(1);
               sec_step  = sec_ff - LB'(1);
               if (item_ff == LB'(1)) begin
                  fend = 1'b1;
                  if (ph_ff == bhrsp_pkg::PH_NAME) begin
                     if (sec_ff == LB'(1)) begin
                        err_step = bhrsp_pkg::ERR_OVERRUN;
                     end else begin
                        ph_step = bhrsp_pkg::PH_VALLEN;
                     end
                  end else if (sec_ff == LB'(1)) begin
                     ph_step = after_section(cur_ff);
                  end else begin
                     ph_step = bhrsp_pkg::PH_NAMELEN;
                  end
               end
            end
            bhrsp_pkg::PH_CONTENT: begin
               item_step = item_ff - LB'(1);
               if (item_ff == LB'(1)) begin
                  cur_step = bhrsp_pkg::SEC_TRAILER;
                  ph_step  = bhrsp_pkg::PH_SECLEN;
               end
            end
            default: begin
            end
         endcase
      end

      if (last_byte) begin
         if (err_step == bhrsp_pkg::ERR_NONE && ph_step != bhrsp_pkg::PH_PAD) begin
            err_step = bhrsp_pkg::ERR_TRUNCATED;
         end
         done = (err_step == bhrsp_pkg::ERR_NONE);
      end

      result.byte_out     = data_byte;
      result.byte_class   = cls;
      result.section_kind = kind;
      result.field_end    = fend;
      result.final_status = status_step;
      result.error_code   = err_step;
      result.message_done = done;

      if (last_byte) begin
         ph_in     = bhrsp_pkg::PH_FRAMING;
         acc_in    = '0;
         left_in   = '0;
         sec_in    = '0;
         item_in   = '0;
         cur_in    = bhrsp_pkg::SEC_INFO;
         status_in = '0;
         err_in    = bhrsp_pkg::ERR_NONE;
      end else begin
         ph_in     = ph_step;
         acc_in    = acc_step;
         left_in   = left_step;
         sec_in    = sec_step;
         item_in   = item_step;
         cur_in    = cur_step;
         status_in = status_step;
         err_in    = err_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= bhrsp_pkg::PH_FRAMING;
         acc_ff    <= '0;
         left_ff   <= '0;
         sec_ff    <= '0;
         item_ff   <= '0;
         cur_ff    <= bhrsp_pkg::SEC_INFO;
         status_ff <= '0;
         err_ff    <= bhrsp_pkg::ERR_NONE;
      end else if (step_en) begin
         ph_ff     <= ph_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         sec_ff    <= sec_in;
         item_ff   <= item_in;
         cur_ff    <= cur_in;
         status_ff <= status_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bhttp_response_stream_parser.sv =====
// Top level: input register, parser core and result register.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    data_byte[7:0], last_byte
//   rsp_chan   out  valid/ready    byte_out, byte_class, section_kind, field_end,
//                                  final_status, error_code, message_done
//
// One item per cycle sustained while rsp_chan is ready; a byte passes the input register,
// then the result register. The parser state steps when the input register moves into
// the result register, so the 62-bit length decrement and compare set the cycle time.
// Synchronous reset returns the parser to the framing indicator; the last byte of a
// message does the same. A stalled result holds while one more input item is taken.
`default_nettype none
module bhttp_response_stream_parser (
   input  wire logic     clock,
   input  wire logic     reset,
   bhrsp_req_if.sink     req_chan,
   bhrsp_rsp_if.source   rsp_chan
);

   logic                           in_valid_ff, in_valid_in;
   logic [bhrsp_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff, out_valid_in;
   bhrsp_pkg::rsp_item_type        out_item_ff;
   bhrsp_pkg::rsp_item_type        core_item;
   logic                           advance;
   logic                           take;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign in_valid_in    = take || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   bhrsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (core_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance) begin
         out_item_ff <= core_item;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.byte_out     = out_item_ff.byte_out;
   assign rsp_chan.byte_class   = out_item_ff.byte_class;
   assign rsp_chan.section_kind = out_item_ff.section_kind;
   assign rsp_chan.field_end    = out_item_ff.field_end;
   assign rsp_chan.final_status = out_item_ff.final_status;
   assign rsp_chan.error_code   = out_item_ff.error_code;
   assign rsp_chan.message_done = out_item_ff.message_done;

endmodule
`default_nettype wire
